@@ sv/sfl_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfl_pkg
// Shared sizes, register indexes, controller states, lane control and the sine entry function.
// ----------------------------------------------------------------------------
package sfl_pkg;

    localparam int LINE_DEPTH  = 4096;
    localparam int SINE_POINTS = 1024;
    localparam int SAMPLE_BITS = 24;
    localparam int ADDR_BITS   = $clog2(LINE_DEPTH);
    localparam int SINE_BITS   = $clog2(SINE_POINTS);
    localparam int CFG_BITS    = 32;
    localparam int IDX_BITS    = 3;
    localparam int FB_LIMIT    = 31129;

    localparam logic [IDX_BITS-1:0] REG_PHASE_STEP  = 3'd0;
    localparam logic [IDX_BITS-1:0] REG_BASE_DELAY  = 3'd1;
    localparam logic [IDX_BITS-1:0] REG_SWEEP_DEPTH = 3'd2;
    localparam logic [IDX_BITS-1:0] REG_FEEDBACK    = 3'd3;
    localparam logic [IDX_BITS-1:0] REG_WET_MIX     = 3'd4;
    localparam logic [IDX_BITS-1:0] REG_STEREO      = 3'd5;

    typedef logic signed [SAMPLE_BITS-1:0] t_sample;

    typedef enum logic [3:0] {
        ST_CLEAR, ST_IDLE, ST_SINE, ST_SWEEP, ST_DELAY, ST_RD0, ST_RD1,
        ST_INTERP, ST_MUL, ST_WRITE, ST_OUT
    } t_state;

    // Lane control from the sequencer.
    typedef struct packed {
        logic                 we;
        logic                 clear;
        logic [ADDR_BITS-1:0] addr;
        logic                 load_in;
        logic                 cap0;
        logic                 cap1;
        logic                 interp;
        logic                 mul;
        logic                 write;
    } t_lane_ctl;

    // Sine entry in Q15 from a quarter-wave Taylor series, worked out at
    // elaboration only.
    function automatic logic signed [15:0] sine_entry(input int k);
        longint unsigned turn, a, x, x2, t, s;
        int unsigned quad;
        turn = (longint'(k % SINE_POINTS) << 32) / SINE_POINTS;
        quad = int'((turn >> 30) & 3);
        a    = turn & 64'h3FFF_FFFF;
        if (quad[0]) begin
            a = 64'h4000_0000 - a;
        end
        x  = (a * 64'd1686629713) >> 30;
        x2 = (x * x) >> 30;
        t  = 64'h4000_0000 - x2 / 72;
        t  = 64'h4000_0000 - ((x2 * t) >> 30) / 42;
        t  = 64'h4000_0000 - ((x2 * t) >> 30) / 20;
        t  = 64'h4000_0000 - ((x2 * t) >> 30) / 6;
        s  = (x * t) >> 30;
        s  = (s + 16384) >> 15;
        if (s > 32767) begin
            s = 32767;
        end
        return quad[1] ? -16'(s) : 16'(s);
    endfunction

endpackage

@@ sv/sfl_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfl_ram
// Single-port RAM with registered read data.
// ----------------------------------------------------------------------------
module sfl_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end
endmodule

@@ sv/sfl_lane.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfl_lane
// One channel: delay line, interpolation, feedback write and dry/wet mix.
// ----------------------------------------------------------------------------
module sfl_lane (
    input  logic                  i_clk,
    input  sfl_pkg::t_lane_ctl    i_ctl,
    input  sfl_pkg::t_sample      i_sample,
    input  logic [7:0]            i_frac,
    input  logic signed [15:0]    i_fb,
    input  logic [16:0]           i_mix,
    output sfl_pkg::t_sample      o_out
);
    import sfl_pkg::*;

    localparam int SB = SAMPLE_BITS;

    logic [SB-1:0]        w_rdata;
    logic [SB-1:0]        w_wdata;
    logic signed [SB-1:0] r_in, r_tap0, r_tap1, r_dly, r_line;
    logic signed [SB+9:0] w_int;
    logic signed [SB+16:0] r_fbp;
    logic signed [SB+18:0] r_mixp;
    logic signed [SB+1:0]  w_lsum;
    logic signed [SB+2:0]  w_osum;

    sfl_ram #(.WIDTH(SB), .DEPTH(LINE_DEPTH)) u_line (
        .i_clk  (i_clk),
        .i_we   (i_ctl.we),
        .i_addr (i_ctl.addr),
        .i_wdata(w_wdata),
        .o_rdata(w_rdata)
    );

    assign w_wdata = i_ctl.clear ? '0 : r_line;
    assign w_int = (SB+10)'(r_tap0) * $signed({2'b0, 9'd256 - {1'b0, i_frac}})
                 + (SB+10)'(r_tap1) * $signed({3'b0, i_frac}) + (SB+10)'(128);
    assign w_lsum = (SB+2)'(r_in) + (SB+2)'((r_fbp + (SB+17)'(16384)) >>> 15);
    assign w_osum = (SB+3)'((r_mixp + (SB+19)'(32768)) >>> 16);

    function automatic logic signed [SB-1:0] sat(input logic signed [SB+2:0] v);
        if (v > (SB+3)'((1 <<< (SB-1)) - 1)) begin
            return {1'b0, {(SB-1){1'b1}}};
        end else if (v < -(SB+3)'(1 <<< (SB-1))) begin
            return {1'b1, {(SB-1){1'b0}}};
        end
        return SB'(v);
    endfunction

    always_ff @(posedge i_clk) begin
        if (i_ctl.load_in) begin
            r_in <= i_sample;
        end
        if (i_ctl.cap0) begin
            r_tap0 <= $signed(w_rdata);
        end
        if (i_ctl.cap1) begin
            r_tap1 <= $signed(w_rdata);
        end
        if (i_ctl.interp) begin
            r_dly <= SB'(w_int >>> 8);
        end
        if (i_ctl.mul) begin
            r_fbp  <= i_fb * r_dly;
            r_mixp <= $signed({1'b0, 17'(18'h10000 - {1'b0, i_mix})}) * r_in
                    + $signed({1'b0, i_mix}) * r_dly;
        end
        if (i_ctl.write) begin
            r_line <= sat((SB+3)'(w_lsum));
            o_out  <= sat(w_osum);
        end
    end
endmodule

@@ sv/stereo_flanger_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stereo_flanger_unit
// LFO-swept stereo flanger with feedback, two lanes sharing one sequencer.
// ----------------------------------------------------------------------------
// Input requests carry one stereo frame (i_left_sample, i_right_sample) on
// i_in_valid / o_in_stall; results leave on o_out_valid / i_out_stall, one
// frame per request. Registers are written through i_cfg_we, i_cfg_index and
// i_cfg_data; the user is to write them only while the block is idle, which
// the block itself does not enforce.
// The sequencer walks the sine lookup, the sweep multiply, both line reads
// through the single RAM port, interpolation, the products and the
// write-back. The next frame is taken once the result has been accepted.
// After reset the delay lines are cleared by a pass over all 4096 entries,
// one entry per cycle in both lanes, during which no request is accepted.
// While the receiver stalls, the result holds and no new frame enters.
// Mono mode leaves the right line untouched and drives zero on the right.
// ----------------------------------------------------------------------------
module stereo_flanger_unit (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    output logic                      o_in_stall,
    input  sfl_pkg::t_sample          i_left_sample,
    input  sfl_pkg::t_sample          i_right_sample,
    output logic                      o_out_valid,
    input  logic                      i_out_stall,
    output sfl_pkg::t_sample          o_left_out,
    output sfl_pkg::t_sample          o_right_out,
    input  logic                      i_cfg_we,
    input  logic [sfl_pkg::IDX_BITS-1:0] i_cfg_index,
    input  logic [sfl_pkg::CFG_BITS-1:0] i_cfg_data
);
    import sfl_pkg::*;

    localparam int QTR_BITS = SINE_BITS - 2;
    localparam logic signed [15:0] SINE_PEAK = sine_entry(SINE_POINTS / 4);

    t_state r_state, n_state;
    logic [31:0] r_step, r_phase;
    logic [19:0] r_base, r_depth;
    logic signed [15:0] r_fb, w_fb;
    logic [16:0] r_mix, w_mix;
    logic r_stereo, r_mono_frame;
    logic [ADDR_BITS-1:0] r_wp, r_addr0, r_addr1, r_clr;
    logic signed [15:0] r_sine;
    logic [36:0] r_sweep;
    logic [20:0] w_delay;
    logic [7:0]  r_frac;
    t_lane_ctl w_ctl, w_ctl_r;
    t_sample w_lo, w_ro;
    logic r_out_valid;
    logic signed [15:0]   w_qrom [SINE_POINTS / 4];
    logic [SINE_BITS-1:0] w_sidx;
    logic [QTR_BITS-1:0]  w_qidx;
    logic signed [15:0]   w_qval;

    // Quarter-wave table; the other quarters come from mirroring and sign.
    for (genvar g = 0; g < SINE_POINTS / 4; g++) begin : g_qrom
        assign w_qrom[g] = sine_entry(g);
    end

    assign w_sidx = r_phase[31 -: SINE_BITS];
    assign w_qidx = w_sidx[SINE_BITS-2] ? -w_sidx[QTR_BITS-1:0] : w_sidx[QTR_BITS-1:0];
    // The crest of each half lies one entry past the end of the quarter table.
    assign w_qval = (w_sidx[SINE_BITS-2] && (w_sidx[QTR_BITS-1:0] == '0)) ? SINE_PEAK
                  : w_qrom[w_qidx];

    assign w_fb  = (r_fb > 16'sd31129) ? 16'sd31129 :
                   (r_fb < -16'sd31129) ? -16'sd31129 : r_fb;
    assign w_mix = (r_mix > 17'd65536) ? 17'd65536 : r_mix;
    assign w_delay = {1'b0, r_base} + 21'(r_sweep >> 16);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= 32'd26844; r_base <= 20'd12288; r_depth <= 20'd36864;
            r_fb <= 16'sd16384; r_mix <= 17'd32768; r_stereo <= 1'b1;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_PHASE_STEP:  r_step   <= i_cfg_data;
                REG_BASE_DELAY:  r_base   <= i_cfg_data[19:0];
                REG_SWEEP_DEPTH: r_depth  <= i_cfg_data[19:0];
                REG_FEEDBACK:    r_fb     <= $signed(i_cfg_data[15:0]);
                REG_WET_MIX:     r_mix    <= i_cfg_data[16:0];
                REG_STEREO:      r_stereo <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR; r_clr <= '0; r_wp <= '0; r_phase <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_CLEAR) r_clr <= r_clr + 1'b1;
            if (r_state == ST_WRITE) begin
                r_wp <= r_wp + 1'b1;
                r_phase <= r_phase + r_step;
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_IDLE) r_mono_frame <= !r_stereo;
        if (r_state == ST_SINE) r_sine <= w_sidx[SINE_BITS-1] ? -w_qval : w_qval;
        if (r_state == ST_SWEEP)
            r_sweep <= {17'b0, r_depth} * 37'(17'(32768 + 32'(r_sine)));
        if (r_state == ST_DELAY) begin
            r_frac  <= w_delay[7:0];
            r_addr0 <= r_wp - w_delay[8 +: ADDR_BITS];
            r_addr1 <= r_wp - w_delay[8 +: ADDR_BITS] - 1'b1;
        end
    end

    always_comb begin
        n_state = r_state;
        w_ctl = '0;
        w_ctl.addr = r_wp;
        case (r_state)
            ST_CLEAR: begin
                w_ctl.we = 1'b1; w_ctl.clear = 1'b1; w_ctl.addr = r_clr;
                if (&r_clr) n_state = ST_IDLE;
            end
            ST_IDLE: if (i_in_valid && !r_out_valid) begin
                w_ctl.load_in = 1'b1; n_state = ST_SINE;
            end
            ST_SINE:  n_state = ST_SWEEP;
            ST_SWEEP: n_state = ST_DELAY;
            ST_DELAY: n_state = ST_RD0;
            ST_RD0: begin w_ctl.addr = r_addr0; n_state = ST_RD1; end
            ST_RD1: begin w_ctl.addr = r_addr1; w_ctl.cap0 = 1'b1; n_state = ST_INTERP; end
            ST_INTERP: begin w_ctl.cap1 = 1'b1; n_state = ST_MUL; end
            ST_MUL: begin w_ctl.interp = 1'b1; n_state = ST_OUT; end
            ST_OUT: begin w_ctl.mul = 1'b1; n_state = ST_WRITE; end
            ST_WRITE: begin w_ctl.write = 1'b1; n_state = ST_IDLE; end
            default: n_state = ST_IDLE;
        endcase
    end

    // The line write is delayed through r_we_d so that it uses the saturated value registered in r_line.
    logic r_we_d;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_we_d <= 1'b0;
        else          r_we_d <= (r_state == ST_WRITE);
    end

    always_comb begin
        w_ctl_r = w_ctl;
        if (r_we_d) begin
            w_ctl_r.we = 1'b1;
            w_ctl_r.addr = r_wp - 1'b1;
        end
    end

    t_lane_ctl w_ctl_right;
    always_comb begin
        w_ctl_right = w_ctl_r;
        if (r_mono_frame && r_state != ST_CLEAR) w_ctl_right.we = 1'b0;
    end

    sfl_lane u_left (
        .i_clk(i_clk), .i_ctl(w_ctl_r), .i_sample(i_left_sample), .i_frac(r_frac),
        .i_fb(w_fb), .i_mix(w_mix), .o_out(w_lo)
    );
    sfl_lane u_right (
        .i_clk(i_clk), .i_ctl(w_ctl_right), .i_sample(i_right_sample),
        .i_frac(r_frac), .i_fb(w_fb), .i_mix(w_mix), .o_out(w_ro)
    );

    // Merge: the right lane is muted for frames taken in mono mode.
    assign o_left_out  = w_lo;
    assign o_right_out = r_mono_frame ? '0 : w_ro;
    assign o_out_valid = r_out_valid;
    assign o_in_stall  = !(r_state == ST_IDLE && !r_out_valid);
endmodule

@@ verif/tb_stereo_flanger_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_stereo_flanger_unit
// Self-checking bench for the stereo flanger: frames are pushed through the
// valid/stall handshake with random gaps on both sides, registers are set to
// a series of settings between phases, and every result frame is compared
// with the frame that a local model of the LFO, delay lines and mix expects.
// ----------------------------------------------------------------------------
module tb_stereo_flanger_unit;
    import sfl_pkg::*;

    localparam logic [IDX_BITS-1:0] REG_SPARE_LO = 3'd6;
    localparam logic [IDX_BITS-1:0] REG_SPARE_HI = 3'd7;
    localparam int CYCLE_LIMIT = 400000;

    typedef struct {
        t_sample left;
        t_sample right;
    } t_frame;

    class flanger_scoreboard;
        logic signed [15:0] sine_rom[SINE_POINTS];
        t_sample lines[2][LINE_DEPTH];
        logic [ADDR_BITS-1:0] wr_pos;
        logic [31:0] phase;
        logic [31:0] step;
        logic [19:0] base;
        logic [19:0] depth;
        logic signed [15:0] fb_gain;
        logic [16:0] mix;
        logic stereo;
        t_frame expected_frames[$];
        int errors;

        function new();
            longint unsigned turn, a, x, x2, t, s;
            for (int k = 0; k < SINE_POINTS; k++) begin
                turn = (longint'(k) << 32) / SINE_POINTS;
                a = turn & 64'h3FFF_FFFF;
                if (turn[30]) begin
                    a = 64'h4000_0000 - a;
                end
                x  = (a * 64'd1686629713) >> 30;
                x2 = (x * x) >> 30;
                t  = 64'h4000_0000 - x2 / 72;
                t  = 64'h4000_0000 - ((x2 * t) >> 30) / 42;
                t  = 64'h4000_0000 - ((x2 * t) >> 30) / 20;
                t  = 64'h4000_0000 - ((x2 * t) >> 30) / 6;
                s  = (((x * t) >> 30) + 16384) >> 15;
                if (s > 32767) begin
                    s = 32767;
                end
                sine_rom[k] = turn[31] ? -16'(s) : 16'(s);
            end
            foreach (lines[i, j]) begin
                lines[i][j] = '0;
            end
            wr_pos  = '0;
            phase   = '0;
            step    = 32'd26844;
            base    = 20'd12288;
            depth   = 20'd36864;
            fb_gain = 16'sd16384;
            mix     = 17'd32768;
            stereo  = 1'b1;
            errors  = 0;
        endfunction

        function void write_reg(logic [IDX_BITS-1:0] idx, logic [CFG_BITS-1:0] data);
            case (idx)
                REG_PHASE_STEP:  step    = data;
                REG_BASE_DELAY:  base    = data[19:0];
                REG_SWEEP_DEPTH: depth   = data[19:0];
                REG_FEEDBACK:    fb_gain = data[15:0];
                REG_WET_MIX:     mix     = data[16:0];
                REG_STEREO:      stereo  = data[0];
                default: ;
            endcase
        endfunction

        // Round to nearest, ties toward plus infinity.
        function longint round_down(longint v, int n);
            return (v + (longint'(1) << (n - 1))) >>> n;
        endfunction

        function longint clip(longint v);
            if (v > 8388607) return 8388607;
            if (v < -8388608) return -8388608;
            return v;
        endfunction

        function t_sample process_lane(int lane, t_sample in_s, int whole, longint frac,
                                       longint fb, longint wet);
            logic [ADDR_BITS-1:0] r0, r1;
            longint delayed;
            r0 = wr_pos - ADDR_BITS'(whole);
            r1 = r0 - 1'b1;
            delayed = round_down(longint'(lines[lane][r0]) * (256 - frac) +
                                 longint'(lines[lane][r1]) * frac, 8);
            lines[lane][wr_pos] = t_sample'(clip(in_s + round_down(fb * delayed, 15)));
            return t_sample'(clip(round_down((65536 - wet) * in_s + wet * delayed, 16)));
        endfunction

        function void note_request(t_sample l, t_sample r);
            longint sweep, dly, fb, wet;
            t_frame f;
            sweep = (longint'(depth) * (32768 + longint'(sine_rom[phase[31:22]]))) >>> 16;
            dly = longint'(base) + sweep;
            fb = fb_gain;
            if (fb > FB_LIMIT) fb = FB_LIMIT;
            if (fb < -FB_LIMIT) fb = -FB_LIMIT;
            wet = (mix > 17'd65536) ? 65536 : longint'(mix);
            f.left = process_lane(0, l, int'(dly >>> 8), dly & 255, fb, wet);
            f.right = stereo ? process_lane(1, r, int'(dly >>> 8), dly & 255, fb, wet) : '0;
            wr_pos = wr_pos + 1'b1;
            phase = phase + step;
            expected_frames = {expected_frames, f};
        endfunction

        function void check_result(t_sample l, t_sample r);
            t_frame e;
            if (expected_frames.size() == 0) begin
                $display("%0t: unexpected result left %0d right %0d", $time, l, r);
                errors++;
                return;
            end
            e = expected_frames.pop_front();
            if (l !== e.left) begin
                $display("%0t: left_out expected %0d actual %0d", $time, e.left, l);
                errors++;
            end
            if (r !== e.right) begin
                $display("%0t: right_out expected %0d actual %0d", $time, e.right, r);
                errors++;
            end
        endfunction

        function int pending();
            return expected_frames.size();
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    t_sample left_in = '0;
    t_sample right_in = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    t_sample left_out, right_out;
    logic cfg_we = 1'b0;
    logic [IDX_BITS-1:0] cfg_index = '0;
    logic [CFG_BITS-1:0] cfg_data = '0;
    logic quiet = 1'b0;
    int cycles = 0;
    flanger_scoreboard sb = new();

    stereo_flanger_unit u_top (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_in_valid(in_valid), .o_in_stall(in_stall),
        .i_left_sample(left_in), .i_right_sample(right_in),
        .o_out_valid(out_valid), .i_out_stall(out_stall),
        .o_left_out(left_out), .o_right_out(right_out),
        .i_cfg_we(cfg_we), .i_cfg_index(cfg_index), .i_cfg_data(cfg_data)
    );

    initial begin
        forever #5 clk = ~clk;
    end

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
        if (rst_n && in_valid && !in_stall) begin
            sb.note_request(left_in, right_in);
        end
        if (rst_n && out_valid && !out_stall) begin
            sb.check_result(left_out, right_out);
        end
    end

    always @(negedge clk) begin
        out_stall <= !quiet && ($urandom_range(99) < 15);
    end

    // Bits above the register width are filled with noise; the block drops them.
    task automatic write_reg(logic [IDX_BITS-1:0] idx, logic [CFG_BITS-1:0] value,
                             logic [CFG_BITS-1:0] mask);
        logic [CFG_BITS-1:0] data;
        data = (value & mask) | ($urandom & ~mask);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        sb.write_reg(idx, data);
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic drain();
        while (sb.pending() != 0) @(posedge clk);
        repeat (20) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic send_frame(t_sample l, t_sample r);
        while (!quiet && $urandom_range(99) < 15) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        left_in <= l;
        right_in <= r;
        do @(posedge clk); while (in_stall);
        @(negedge clk);
    endtask

    task automatic stop_sending();
        in_valid <= 1'b0;
        @(negedge clk);
    endtask

    function automatic t_sample pick_sample();
        case ($urandom_range(9))
            0: return 24'sh7FFFFF;
            1: return 24'sh800000;
            default: return t_sample'($urandom);
        endcase
    endfunction

    task automatic random_settings();
        case ($urandom_range(3))
            0: write_reg(REG_PHASE_STEP, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
            1: write_reg(REG_PHASE_STEP, $urandom, 32'hFFFF_FFFF);
            default: write_reg(REG_PHASE_STEP, $urandom_range(0, 20000000), 32'hFFFF_FFFF);
        endcase
        // Short delays keep the taps inside the part of the line already written.
        write_reg(REG_BASE_DELAY, ($urandom_range(7) == 0) ? 32'hFFFFF
                  : $urandom_range(0, 48 * 256), 32'hF_FFFF);
        write_reg(REG_SWEEP_DEPTH, ($urandom_range(7) == 0) ? 32'hFFFFF
                  : $urandom_range(0, 32 * 256), 32'hF_FFFF);
        write_reg(REG_FEEDBACK, $urandom_range(0, 65535), 32'hFFFF);
        write_reg(REG_WET_MIX, ($urandom_range(5) == 0) ? $urandom_range(0, 32'h1FFFF)
                  : $urandom_range(0, 65536), 32'h1_FFFF);
        write_reg(REG_STEREO, $urandom_range(1), 32'h1);
    endtask

    initial begin
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Reset settings with sample extremes.
        send_frame(24'sh7FFFFF, 24'sh800000);
        send_frame(24'sh800000, 24'sh7FFFFF);
        send_frame('0, '0);
        send_frame(24'sh555555, 24'shAAAAAA);
        send_frame(24'shAAAAAA, 24'sh555555);
        send_frame(24'sh7FFFFF, 24'sh7FFFFF);
        stop_sending();
        drain();

        // Zero delay, feedback above the clamp, mix above one, largest phase step.
        write_reg(REG_BASE_DELAY, 0, 32'hF_FFFF);
        write_reg(REG_SWEEP_DEPTH, 0, 32'hF_FFFF);
        write_reg(REG_FEEDBACK, 32'h7FFF, 32'hFFFF);
        write_reg(REG_WET_MIX, 32'h1FFFF, 32'h1_FFFF);
        write_reg(REG_PHASE_STEP, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        for (int i = 0; i < 6; i++) begin
            send_frame((i % 2) ? 24'sh800000 : 24'sh7FFFFF, 24'sh7FFFFF);
        end
        stop_sending();
        drain();

        // Delay past the line end, feedback below the clamp, dry only, mono.
        write_reg(REG_BASE_DELAY, 32'hFFFFF, 32'hF_FFFF);
        write_reg(REG_SWEEP_DEPTH, 32'hFFFFF, 32'hF_FFFF);
        write_reg(REG_FEEDBACK, 32'h8000, 32'hFFFF);
        write_reg(REG_WET_MIX, 0, 32'h1_FFFF);
        write_reg(REG_STEREO, 0, 32'h1);
        write_reg(REG_SPARE_LO, $urandom, 32'h0);
        write_reg(REG_SPARE_HI, $urandom, 32'h0);
        for (int i = 0; i < 6; i++) begin
            send_frame(24'sh800000, 24'sh7FFFFF);
        end
        stop_sending();
        drain();

        for (int p = 0; p < 7; p++) begin
            random_settings();
            for (int i = 0; i < 100; i++) begin
                quiet <= (p == 2);
                send_frame(pick_sample(), pick_sample());
            end
            quiet <= 1'b0;
            stop_sending();
            drain();
        end

        if (sb.errors == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
